>>> hdl/best_fit_heap_allocator_assert.svh
// ----------------------------------------------------------------------------
// best-fit heap allocator assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// plain property check
`define BFH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication check
`define BFH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BFH_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hdl/bfh_pkg.sv
// ----------------------------------------------------------------------------
// bfh_pkg
// shared types and codes of the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfh_pkg;

  // one table entry
  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic        free;
  } entry_t;

  // broadcast control to the cell row
  typedef struct packed {
    logic   shift;
    logic   wr;
    entry_t wdata;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_NULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BASE   = 2'd0,
    REG_INIT   = 2'd1,
    REG_GROWTH = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_e;

endpackage

>>> hdl/bfh_if.sv
// ----------------------------------------------------------------------------
// bfh channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bfh_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] request_size;
  logic [47:0] release_address;

  modport source (output valid, command, request_size, release_address, input ready);
  modport sink   (input valid, command, request_size, release_address, output ready);
endinterface

interface bfh_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] granted_address;
  logic [2:0]  status;

  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

>>> hdl/bfh_cell.sv
// ----------------------------------------------------------------------------
// bfh_cell
// one table slot: loads from its right neighbor on a shift, or a broadcast write
// ----------------------------------------------------------------------------
module bfh_cell #(
  parameter int IW = 6,
  parameter int IDX = 0,
  parameter bfh_pkg::entry_t RST_ENTRY = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfh_pkg::cell_ctl_t ctl_i,
  input  logic [IW-1:0]      wr_idx_i,
  input  bfh_pkg::entry_t    right_i,
  output bfh_pkg::entry_t    ent_o
);
  import bfh_pkg::*;

  entry_t ent_q;
  logic   sel;

  // address decode of the broadcast write
  assign sel = ctl_i.wr && (wr_idx_i == IW'(IDX));

  // slot storage, write wins over shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= RST_ENTRY;
    end else if (sel) begin
      ent_q <= ctl_i.wdata;
    end else if (ctl_i.shift) begin
      ent_q <= right_i;
    end
  end

  assign ent_o = ent_q;
endmodule

>>> hdl/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// best-fit heap with split and coalesce over a row of shifting table cells
// ----------------------------------------------------------------------------
// zero size or null free skip the scan and go straight to the done state; otherwise
//   a scan pass over the n table entries and a rewrite pass follow, with a step
//   and a grow state between them when the heap has to grow
// one word in flight at a time; the table rotates through cell 0 once per pass
// the page round-up is a mask on the power-of-two page size
// reset: heap set up from reset registers, one free block, output empty
`include "best_fit_heap_allocator_assert.svh"

module best_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfh_in_if.sink      req_i,
  bfh_out_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bfh_pkg::*;

  localparam int N   = MAX_BLOCKS;
  localparam int IW  = $clog2(N);
  localparam int CW  = $clog2(N + 1);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [34:0] HDR35 = 35'(HEADER_BYTES);
  localparam logic [34:0] PG_M1 = 35'(PAGE_BYTES - 1);
  localparam logic [31:0] RST_INIT   = 32'd2097152;
  localparam logic [31:0] RST_GROWTH = 32'd1048576;
  localparam logic [31:0] RST_LIMIT  = 32'hFFFF_FFFF;
  localparam entry_t CELL0_RST = '{off: 32'd0, size: RST_INIT - HDR32, free: 1'b1};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_STEP  = 6'b000100,
    S_GROW  = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // registers
  state_e          st_q, st_d;
  logic [47:0]     base_q, base_d;
  logic [31:0]     init_q, init_d;
  logic [31:0]     gstep_q, gstep_d;
  logic [31:0]     limit_q, limit_d;
  logic [32:0]     hend_q, hend_d;
  logic [CW-1:0]   len_q, len_d;
  logic            cmd_q, cmd_d;
  logic [32:0]     need_q, need_d;
  logic [47:0]     target_q, target_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   nq_q, nq_d;
  logic            bv_q, bv_d;
  logic [IW-1:0]   best_q, best_d;
  logic [31:0]     bsize_q, bsize_d;
  entry_t          last_q, last_d;
  logic [34:0]     step_q, step_d;
  logic            split_q, split_d;
  logic            pv_q, pv_d;
  entry_t          pend_q, pend_d;
  status_e         stat_q, stat_d;
  logic [47:0]     gaddr_q, gaddr_d;
  logic            ov_q, ov_d;
  logic [47:0]     ogaddr_q, ogaddr_d;
  logic [2:0]      ostat_q, ostat_d;

  // cell row
  cell_ctl_t       ctl;
  logic [IW-1:0]   wr_idx;
  entry_t          ents [N];
  entry_t          head;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      entry_t right;
      if (gi == N - 1) begin : g_end
        assign right = ents[gi];
      end else begin : g_mid
        assign right = ents[gi + 1];
      end
      bfh_cell #(
        .IW        (IW),
        .IDX       (gi),
        .RST_ENTRY ((gi == 0) ? CELL0_RST : entry_t'('0))
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .wr_idx_i (wr_idx),
        .right_i  (right),
        .ent_o    (ents[gi])
      );
    end
  endgenerate

  assign head = ents[0];

  // handshakes
  logic acc, cfg_wr, out_free;
  reg_e cfg_idx;
  assign acc      = req_i.valid && req_i.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_e'(paddr[4:3]);
  assign pready   = 1'b1;
  assign out_free = !ov_q || rsp_o.ready;
  assign req_i.ready = (st_q == S_IDLE);

  // register read mux
  always_comb begin
    case (cfg_idx)
      REG_BASE:   prdata = {16'd0, base_q};
      REG_INIT:   prdata = {32'd0, init_q};
      REG_GROWTH: prdata = {32'd0, gstep_q};
      REG_LIMIT:  prdata = {32'd0, limit_q};
      default:    prdata = '0;
    endcase
  end

  // datapath helpers
  logic [34:0] want, round, gsum;
  logic [31:0] nsz, init_sz;
  logic        alloc_hit, free_hit, at_b, split_ok, merge;
  logic [CW-1:0] len_m1;
  entry_t      em;

  assign want    = {2'b0, need_q} + HDR35;
  assign round   = (want + PG_M1) & ~PG_M1;
  assign gsum    = {2'b0, hend_q} + step_q;
  assign nsz     = last_q.size + step_q[31:0];
  assign len_m1  = len_q - 1'b1;
  assign at_b    = (cnt_q == CW'(best_q));
  assign alloc_hit = head.free && ({1'b0, head.size} >= need_q) &&
                     (!bv_q || (head.size < bsize_q));
  assign free_hit  = !bv_q && (target_q == {16'd0, head.off});
  assign split_ok  = ({3'b0, head.size} >= ({2'b0, need_q} + HDR35 + 35'd8)) &&
                     (len_q < CW'(N));
  assign em        = '{off: head.off, size: head.size, free: head.free | at_b};
  assign merge     = pv_q && pend_q.free && em.free;

  // control sequencer
  always_comb begin
    st_d = st_q; base_d = base_q; init_d = init_q; gstep_d = gstep_q; limit_d = limit_q;
    hend_d = hend_q; len_d = len_q; cmd_d = cmd_q; need_d = need_q; target_d = target_q;
    cnt_d = cnt_q; nq_d = nq_q; bv_d = bv_q; best_d = best_q; bsize_d = bsize_q;
    last_d = last_q; step_d = step_q; split_d = split_q;
    pv_d = pv_q; pend_d = pend_q; stat_d = stat_q; gaddr_d = gaddr_q;
    ov_d = ov_q; ogaddr_d = ogaddr_q; ostat_d = ostat_q;
    ctl = '0;
    wr_idx = '0;
    init_sz = '0;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        // configuration, heap set up again on base or size writes
        if (cfg_wr) begin
          init_sz = init_q;
          case (cfg_idx)
            REG_BASE:   base_d  = pwdata[47:0];
            REG_INIT: begin
              init_d  = pwdata[31:0];
              init_sz = pwdata[31:0];
            end
            REG_GROWTH: gstep_d = pwdata[31:0];
            REG_LIMIT:  limit_d = pwdata[31:0];
            default: ;
          endcase
          if (cfg_idx == REG_BASE || cfg_idx == REG_INIT) begin
            ctl.wr    = 1'b1;
            ctl.wdata = '{off: 32'd0, size: (init_sz > HDR32) ? init_sz - HDR32 : 32'd0,
                          free: 1'b1};
            len_d     = CW'(1);
            hend_d    = {1'b0, init_sz};
          end
        end
        if (acc) begin
          cmd_d    = req_i.command;
          need_d   = ({1'b0, req_i.request_size} + 33'd7) & ~33'd7;
          target_d = req_i.release_address - base_q - 48'(HEADER_BYTES);
          cnt_d    = '0;
          bv_d     = 1'b0;
          gaddr_d  = '0;
          stat_d   = ST_OK;
          st_d     = S_SCAN;
          if (req_i.command == CMD_ALLOC && req_i.request_size == '0) begin
            stat_d = ST_ZERO;
            st_d   = S_DONE;
          end else if (req_i.command == CMD_FREE && req_i.release_address == '0) begin
            stat_d = ST_NULL;
            st_d   = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // rotate once, best fit or first address match
        ctl.shift = 1'b1;
        ctl.wr    = 1'b1;
        ctl.wdata = head;
        wr_idx    = len_m1[IW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if ((cmd_q == CMD_ALLOC) ? alloc_hit : free_hit) begin
          bv_d    = 1'b1;
          best_d  = cnt_q[IW-1:0];
          bsize_d = head.size;
        end
        if (cnt_q == len_m1) begin
          last_d  = head;
          cnt_d   = '0;
          nq_d    = len_q;
          split_d = 1'b0;
          pv_d    = 1'b0;
          if (bv_q || ((cmd_q == CMD_ALLOC) ? alloc_hit : free_hit)) begin
            st_d = S_APPLY;
          end else if (cmd_q == CMD_ALLOC) begin
            st_d = S_STEP;
          end else begin
            stat_d = ST_UNKNOWN;
            st_d   = S_DONE;
          end
        end
      end

      S_STEP: begin
        step_d = (want > {3'b0, gstep_q}) ? round : {3'b0, gstep_q};
        st_d   = S_GROW;
      end

      S_GROW: begin
        st_d   = S_DONE;
        stat_d = ST_OOM;
        if (gsum > {3'b0, limit_q}) begin
          st_d = S_DONE;
        end else if (last_q.free) begin
          // extend the free last block
          ctl.wr    = 1'b1;
          ctl.wdata = '{off: last_q.off, size: nsz, free: 1'b1};
          wr_idx    = len_m1[IW-1:0];
          hend_d    = gsum[32:0];
          if ({1'b0, nsz} >= need_q) begin
            best_d = len_m1[IW-1:0];
            stat_d = ST_OK;
            st_d   = S_APPLY;
          end
        end else if (len_q < CW'(N)) begin
          // append a new free block at the old heap end
          ctl.wr    = 1'b1;
          ctl.wdata = '{off: hend_q[31:0], size: step_q[31:0] - HDR32, free: 1'b1};
          wr_idx    = len_q[IW-1:0];
          len_d     = len_q + 1'b1;
          nq_d      = len_q + 1'b1;
          hend_d    = gsum[32:0];
          if ({1'b0, step_q[31:0] - HDR32} >= need_q) begin
            best_d = len_q[IW-1:0];
            stat_d = ST_OK;
            st_d   = S_APPLY;
          end
        end
      end

      S_APPLY: begin
        if (cmd_q == CMD_ALLOC) begin
          // grant the chosen block, split off the surplus when it is large and a cell is free
          if (cnt_q == nq_q) begin
            st_d = S_DONE;
          end else if (at_b && !split_q && split_ok) begin
            ctl.wr    = 1'b1;
            ctl.wdata = '{off: head.off, size: need_q[31:0], free: 1'b0};
            wr_idx    = len_q[IW-1:0];
            len_d     = len_q + 1'b1;
            split_d   = 1'b1;
            gaddr_d   = base_q + {16'd0, head.off} + 48'(HEADER_BYTES);
          end else begin
            ctl.shift = 1'b1;
            ctl.wr    = 1'b1;
            wr_idx    = len_m1[IW-1:0];
            cnt_d     = cnt_q + 1'b1;
            ctl.wdata = head;
            if (at_b && split_q) begin
              ctl.wdata = '{off: head.off + HDR32 + need_q[31:0],
                            size: head.size - need_q[31:0] - HDR32, free: 1'b1};
            end else if (at_b) begin
              ctl.wdata = '{off: head.off, size: head.size, free: 1'b0};
              gaddr_d   = base_q + {16'd0, head.off} + 48'(HEADER_BYTES);
            end
          end
        end else begin
          // mark the block free and merge neighboring free blocks
          if (cnt_q == nq_q) begin
            ctl.wr    = 1'b1;
            ctl.wdata = pend_q;
            wr_idx    = len_q[IW-1:0];
            len_d     = len_q + 1'b1;
            st_d      = S_DONE;
          end else begin
            ctl.shift = 1'b1;
            cnt_d     = cnt_q + 1'b1;
            if (merge) begin
              pend_d.size = pend_q.size + HDR32 + em.size;
              len_d       = len_q - 1'b1;
            end else begin
              pend_d = em;
              pv_d   = 1'b1;
              if (pv_q) begin
                ctl.wr    = 1'b1;
                ctl.wdata = pend_q;
                wr_idx    = len_m1[IW-1:0];
              end else begin
                len_d = len_q - 1'b1;
              end
            end
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ogaddr_d = (stat_q == ST_OK) ? gaddr_q : 48'd0;
          ostat_d  = stat_q;
          st_d     = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      base_q  <= '0;
      init_q  <= RST_INIT;
      gstep_q <= RST_GROWTH;
      limit_q <= RST_LIMIT;
      hend_q  <= {1'b0, RST_INIT};
      len_q   <= CW'(1);
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      base_q  <= base_d;
      init_q  <= init_d;
      gstep_q <= gstep_d;
      limit_q <= limit_d;
      hend_q  <= hend_d;
      len_q   <= len_d;
      ov_q    <= ov_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    need_q   <= need_d;
    target_q <= target_d;
    cnt_q    <= cnt_d;
    nq_q     <= nq_d;
    bv_q     <= bv_d;
    best_q   <= best_d;
    bsize_q  <= bsize_d;
    last_q   <= last_d;
    step_q   <= step_d;
    split_q  <= split_d;
    pv_q     <= pv_d;
    pend_q   <= pend_d;
    stat_q   <= stat_d;
    gaddr_q  <= gaddr_d;
    ogaddr_q <= ogaddr_d;
    ostat_q  <= ostat_d;
  end

  assign rsp_o.valid           = ov_q;
  assign rsp_o.granted_address = ogaddr_q;
  assign rsp_o.status          = ostat_q;

  // checks
  `BFH_ASSERT(a_len_range, clk_i, rst_ni, (len_q <= CW'(N)), "table length out of range")
  `BFH_ASSERT_IMPL(a_acc_busy, clk_i, rst_ni, acc, ##1 (st_q != S_IDLE), "accepted word left block idle")
  `BFH_ASSERT_IMPL(a_rsp_src, clk_i, rst_ni, $rose(ov_q), $past(st_q) == S_DONE, "response not from done")
endmodule
